/* sv/sib_pkg.sv */
`default_nettype none
package sib_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int CAPACITY_DEF = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    // Broadcast from the control to every cell in the row.
    typedef struct packed {
        logic                     ins;
        logic                     rot;
        logic signed [DATA_W-1:0] new_val;
    } sib_ctrl_t;

endpackage
`default_nettype wire

/* sv/sorted_insert_buffer_unit.sv */
// Sorted list of up to CAPACITY signed 32-bit values held in a row of
// compare-and-shift cells. An insert leaves busy low, so inserts may follow
// one another on every cycle. A dump of a non-empty list holds busy high
// while the row rotates once, one value leaving the head each cycle; the
// results appear in the cycle after the head is read, each for a single
// cycle with result_valid high. An empty dump gives one result flagged
// empty in the cycle after the start beat. The receiver cannot stall: every
// result must be taken in the cycle it is shown.
`default_nettype none
module sorted_insert_buffer_unit #(
    parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               req_type,
    input  wire logic signed [sib_pkg::DATA_W-1:0]  value,
    output logic                                    result_valid,
    output logic signed [sib_pkg::DATA_W-1:0]       item_value,
    output logic [sib_pkg::POS_W-1:0]               position,
    output logic                                    last_item,
    output logic                                    list_empty,
    output logic                                    overflowed
);

    localparam int CW = $clog2(CAPACITY + 1);

    sib_pkg::sib_ctrl_t                ctrl;
    logic signed [sib_pkg::DATA_W-1:0] cell_val [CAPACITY];
    logic                              cell_ge  [CAPACITY];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] rank_reg;
    logic          dumping_reg;
    logic          overflow_reg;
    logic          strobe_reg;
    logic signed [sib_pkg::DATA_W-1:0] item_reg;
    logic [sib_pkg::POS_W-1:0]         pos_reg;
    logic          last_reg;
    logic          empty_reg;

    logic accept;
    logic full;
    logic dump_start;
    logic at_tail;

    assign busy       = dumping_reg;
    assign accept     = start && !busy;
    assign full       = count_reg == CW'(CAPACITY);
    assign dump_start = accept && (req_type == sib_pkg::REQ_DUMP);
    assign at_tail    = rank_reg == (count_reg - CW'(1));

    assign ctrl.ins     = accept && (req_type == sib_pkg::REQ_INSERT) && !full;
    assign ctrl.rot     = dumping_reg;
    assign ctrl.new_val = value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                              p_ge;
            logic signed [sib_pkg::DATA_W-1:0] p_val;
            logic signed [sib_pkg::DATA_W-1:0] n_val;

            if (g == 0)
            begin : g_first
                assign p_ge  = 1'b0;
                assign p_val = '0;
            end
            else
            begin : g_mid
                assign p_ge  = cell_ge[g-1];
                assign p_val = cell_val[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign n_val = '0;
            end
            else
            begin : g_inner
                assign n_val = cell_val[g+1];
            end

            sib_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .count    (count_reg),
                .prev_ge  (p_ge),
                .prev_val (p_val),
                .next_val (n_val),
                .head_val (cell_val[0]),
                .val      (cell_val[g]),
                .ge       (cell_ge[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rank_reg     <= '0;
            dumping_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.ins)
                count_reg <= count_reg + CW'(1);
            if (accept && (req_type == sib_pkg::REQ_INSERT) && full)
                overflow_reg <= 1'b1;

            if (dump_start)
            begin
                rank_reg    <= '0;
                dumping_reg <= count_reg != '0;
            end
            else if (dumping_reg)
            begin
                rank_reg <= rank_reg + CW'(1);
                if (at_tail)
                    dumping_reg <= 1'b0;
            end

            strobe_reg <= (dump_start && (count_reg == '0)) || dumping_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= dumping_reg ? cell_val[0] : '0;
        pos_reg   <= dumping_reg ? sib_pkg::POS_W'(rank_reg) : '0;
        last_reg  <= dumping_reg ? at_tail : 1'b1;
        empty_reg <= !dumping_reg;
    end

    assign result_valid = strobe_reg;
    assign item_value   = item_reg;
    assign position     = pos_reg;
    assign last_item    = last_reg;
    assign list_empty   = empty_reg;
    assign overflowed   = overflow_reg;

endmodule
`default_nettype wire

/* sv/sib_cell.sv */
`default_nettype none
module sib_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                             clk,
    input  wire sib_pkg::sib_ctrl_t               ctrl,
    input  wire logic [CW-1:0]                    count,
    input  wire logic                             prev_ge,
    input  wire logic signed [sib_pkg::DATA_W-1:0] prev_val,
    input  wire logic signed [sib_pkg::DATA_W-1:0] next_val,
    input  wire logic signed [sib_pkg::DATA_W-1:0] head_val,
    output logic signed [sib_pkg::DATA_W-1:0]      val,
    output logic                                  ge
);

    logic signed [sib_pkg::DATA_W-1:0] val_reg;
    logic signed [sib_pkg::DATA_W-1:0] val_next;
    logic                              occ;
    logic                              tail;

    assign occ  = CW'(IDX) < count;
    assign tail = CW'(IDX) == (count - CW'(1));
    assign ge   = occ && (val_reg >= ctrl.new_val);
    assign val  = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins)
        begin
            // The left neighbour moves up when it is not smaller than the new value.
            if (prev_ge)
                val_next = prev_val;
            else if (!occ || ge)
                val_next = ctrl.new_val;
        end
        else if (ctrl.rot)
        begin
            // During a dump the occupied part of the row rotates towards the head.
            val_next = tail ? head_val : next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire
